// ===== src/nearest_palette_color_mapper_macros.svh =====
// Assertion macros shared by the nearest palette color mapper RTL.
// Depends on nothing; included inside module bodies that assert.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define NPCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define NPCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/npcm_pkg.sv =====
// Package for the nearest palette color mapper: sequencer states, register
// indexes, input mode codes and fixed widths. No dependencies.
`default_nettype none
package npcm_pkg;

  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE     = 3'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MAP   = 1'b1;

  localparam logic [DIST_W-1:0] NO_DIST = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

endpackage
`default_nettype wire

// ===== src/npcm_ifs.sv =====
// Handshake channels of the nearest palette color mapper: pixel/palette
// input, mapped result, configuration write. Uses npcm_pkg widths.
`default_nettype none
interface npcm_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, mode, entry_index, red, green, blue, input ready);
  modport sink (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

interface npcm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] chosen_index;
  logic       bg_substituted;
  modport source (output valid, out_red, out_green, out_blue, chosen_index,
                  bg_substituted, input ready);
  modport sink (input valid, out_red, out_green, out_blue, chosen_index,
                bg_substituted, output ready);
endinterface

interface npcm_cfg_if;
  import npcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/nearest_palette_color_mapper.sv =====
// Top level of the nearest palette color mapper: config registers, palette
// RAM, search sequencer and result register. Uses npcm_pkg, npcm_ifs,
// npcm_ram, npcm_dist and the assertion macro header.
// Palette write: accepted while idle, no result.
// Pixel: one pass over the n searched entries, one palette read per cycle;
//   a second pass for the background cell when bg_enable is set; then the
//   result is loaded, and the next beat is taken only once that is done,
//   which an output stall can delay.
// Synchronous active-high reset clears control state and presets config registers;
//   palette contents are undefined until written.
`default_nettype none
module nearest_palette_color_mapper #(
  parameter int PAL_ENTRIES     = 256,
  parameter int RED_CELL_BITS   = 7,
  parameter int GREEN_CELL_BITS = 7,
  parameter int BLUE_CELL_BITS  = 7
) (
  input wire logic clk,
  input wire logic rst,
  npcm_pix_if.sink   pix,
  npcm_res_if.source res,
  npcm_cfg_if.sink   cfg
);
  import npcm_pkg::*;

  localparam int AW = $clog2(PAL_ENTRIES);
  localparam int RS = 8 - RED_CELL_BITS;
  localparam int GS = 8 - GREEN_CELL_BITS;
  localparam int BS = 8 - BLUE_CELL_BITS;
  localparam logic [7:0] RMASK = 8'(8'hFF << RS);
  localparam logic [7:0] GMASK = 8'(8'hFF << GS);
  localparam logic [7:0] BMASK = 8'(8'hFF << BS);
  localparam logic [7:0] RHALF = 8'((1 << RS) >> 1);
  localparam logic [7:0] GHALF = 8'((1 << GS) >> 1);
  localparam logic [7:0] BHALF = 8'((1 << BS) >> 1);
  localparam logic [COUNT_W-1:0] PAL_N = COUNT_W'(PAL_ENTRIES);

  logic               gray_mode;
  logic [COUNT_W-1:0] color_count;
  logic               bg_enable;
  color_t             bg_col;

  state_t state, state_next;
  logic               pass;
  logic [COUNT_W-1:0] cnt;
  logic [2:0]         v;
  logic [AW-1:0]      idx_d0, idx_d1, idx_d2;
  color_t             col_d1, col_d2;
  logic [DIST_W-1:0]  best_dist;
  logic [AW-1:0]      best_idx;
  color_t             best_col;
  logic [AW-1:0]      pix_idx;
  color_t             pix_col;
  color_t             pix_center, bg_center, cur_center;
  color_t             rdata;
  logic [DIST_W-1:0]  distance;
  logic [COUNT_W-1:0] n_eff;

  logic pix_accept, pal_we, issuing, pass_end, load_out;
  logic [AW-1:0] fin_idx;
  color_t fin_col, cmp_col;
  logic   sub;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_mode   <= 1'b0;
      color_count <= COUNT_W'(1);
      bg_enable   <= 1'b0;
      bg_col      <= '{r: 8'hFF, g: 8'hFF, b: 8'hFF};
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_GRAY_MODE:   gray_mode   <= cfg.data[0];
        CFG_COLOR_COUNT: color_count <= cfg.data;
        CFG_BG_ENABLE:   bg_enable   <= cfg.data[0];
        CFG_BG_RED:      bg_col.r    <= cfg.data[7:0];
        CFG_BG_GREEN:    bg_col.g    <= cfg.data[7:0];
        CFG_BG_BLUE:     bg_col.b    <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (color_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (color_count > PAL_N) begin
      n_eff = PAL_N;
    end else begin
      n_eff = color_count;
    end
  end

  // cell centers
  always_comb begin
    if (gray_mode) begin
      bg_center.r = (bg_col.r & RMASK) | RHALF;
      bg_center.g = (bg_col.r & GMASK) | GHALF;
      bg_center.b = (bg_col.r & BMASK) | BHALF;
    end else begin
      bg_center.r = (bg_col.r & RMASK) | RHALF;
      bg_center.g = (bg_col.g & GMASK) | GHALF;
      bg_center.b = (bg_col.b & BMASK) | BHALF;
    end
    cur_center = pass ? bg_center : pix_center;
  end

  assign pix.ready  = (state == S_IDLE);
  assign pix_accept = pix.valid && pix.ready && (pix.mode == MODE_MAP);
  assign pal_we     = pix.valid && pix.ready && (pix.mode == MODE_WRITE)
                      && ({1'b0, pix.entry_index} < PAL_N);

  npcm_ram #(
    .WIDTH ($bits(color_t)),
    .DEPTH (PAL_ENTRIES)
  ) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pix.entry_index[AW-1:0]),
    .wdata ({pix.red, pix.green, pix.blue}),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  npcm_dist u_dist (
    .clk      (clk),
    .center   (cur_center),
    .entry    (rdata),
    .distance (distance)
  );

  // sequencer outputs
  always_comb begin
    issuing  = (state == S_SEARCH) && (cnt < n_eff);
    pass_end = (state == S_SEARCH) && (cnt >= n_eff) && (v == '0);
    load_out = (state == S_DONE) && (!res.valid || res.ready);
    fin_idx  = pass ? pix_idx : best_idx;
    fin_col  = pass ? pix_col : best_col;
    cmp_col  = best_col;
    if (gray_mode) begin
      sub = pass && (fin_col.r == cmp_col.r);
    end else begin
      sub = pass && (fin_col == cmp_col);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pix_accept) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pass_end && (pass || !bg_enable)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
      cnt   <= '0;
      v     <= '0;
    end else begin
      state <= state_next;
      v     <= {v[1:0], issuing};
      if (pix_accept) begin
        pass <= 1'b0;
        cnt  <= '0;
      end else if (issuing) begin
        cnt <= cnt + COUNT_W'(1);
      end else if (pass_end && !pass && bg_enable) begin
        pass <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    idx_d0 <= cnt[AW-1:0];
    idx_d1 <= idx_d0;
    idx_d2 <= idx_d1;
    col_d1 <= rdata;
    col_d2 <= col_d1;
    if (pix_accept) begin
      if (gray_mode) begin
        pix_center.r <= (pix.red & RMASK) | RHALF;
        pix_center.g <= (pix.red & GMASK) | GHALF;
        pix_center.b <= (pix.red & BMASK) | BHALF;
      end else begin
        pix_center.r <= (pix.red & RMASK) | RHALF;
        pix_center.g <= (pix.green & GMASK) | GHALF;
        pix_center.b <= (pix.blue & BMASK) | BHALF;
      end
    end
    if (pix_accept || (pass_end && !pass)) begin
      best_dist <= NO_DIST;
    end else if (v[2] && (distance < best_dist)) begin
      best_dist <= distance;
      best_idx  <= idx_d2;
      best_col  <= col_d2;
    end
    if (pass_end && !pass) begin
      pix_idx <= best_idx;
      pix_col <= best_col;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.chosen_index   <= 8'(fin_idx);
      res.bg_substituted <= sub;
      if (sub) begin
        res.out_red <= bg_col.r;
      end else begin
        res.out_red <= fin_col.r;
      end
      if (gray_mode) begin
        res.out_green <= 8'd0;
        res.out_blue  <= 8'd0;
      end else if (sub) begin
        res.out_green <= bg_col.g;
        res.out_blue  <= bg_col.b;
      end else begin
        res.out_green <= fin_col.g;
        res.out_blue  <= fin_col.b;
      end
    end
  end

  `include "nearest_palette_color_mapper_macros.svh"

  `NPCM_ASSERT_IMP(a_idle_empty, clk, rst, state == S_IDLE, v == '0, "pipeline busy while idle")
  `NPCM_ASSERT_IMP(a_cnt_bound, clk, rst, state == S_SEARCH, cnt <= n_eff, "issue count past end")
  `NPCM_ASSERT_IMP(a_sub_bg, clk, rst, load_out && sub, bg_enable, "substitution without bg")
  `NPCM_ASSERT_IMP(a_gray_zero, clk, rst, res.valid && gray_mode,
                   res.out_green == 8'd0 && res.out_blue == 8'd0, "gray result not zeroed")
  `NPCM_ASSERT_NXT(a_load_valid, clk, rst, load_out, res.valid, "loaded result not valid")

endmodule
`default_nettype wire

// ===== src/npcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module npcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/npcm_dist.sv =====
// Two-stage weighted squared distance unit: squares, then sum.
// Depends on npcm_pkg for color_t and DIST_W.
`default_nettype none
module npcm_dist (
  input  wire logic                  clk,
  input  wire npcm_pkg::color_t      center,
  input  wire npcm_pkg::color_t      entry,
  output logic [npcm_pkg::DIST_W-1:0] distance
);
  import npcm_pkg::*;

  logic [7:0]  ar, ag, ab;
  logic [8:0]  dr;
  logic [9:0]  dg;
  logic [17:0] sq_r;
  logic [19:0] sq_g;
  logic [15:0] sq_b;

  always_comb begin
    ar = (center.r > entry.r) ? center.r - entry.r : entry.r - center.r;
    ag = (center.g > entry.g) ? center.g - entry.g : entry.g - center.g;
    ab = (center.b > entry.b) ? center.b - entry.b : entry.b - center.b;
    dr = {ar, 1'b0};
    dg = 10'({ag, 1'b0}) + 10'(ag);
  end

  always_ff @(posedge clk) begin
    sq_r     <= 18'(dr) * 18'(dr);
    sq_g     <= 20'(dg) * 20'(dg);
    sq_b     <= 16'(ab) * 16'(ab);
    distance <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

endmodule
`default_nettype wire

// ===== tb/sv/npcm_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the nearest palette color mapper testbench: a predictor of the
// weighted palette search and a queue of expected mapped pixels. Uses npcm_pkg.
package npcm_tb_pkg;
  import npcm_pkg::*;

  localparam int PAL_ENTRIES     = 256;
  localparam int RED_CELL_BITS   = 7;
  localparam int GREEN_CELL_BITS = 7;
  localparam int BLUE_CELL_BITS  = 7;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] idx;
    logic       sub;
  } mapped_pixel_t;

  class palette_map_scoreboard;
    color_t             palette [PAL_ENTRIES];
    logic               gray;
    logic [COUNT_W-1:0] count;
    logic               bg_on;
    color_t             bg;
    mapped_pixel_t      expected_q [$];
    int                 errors;

    function new();
      gray   = 1'b0;
      count  = COUNT_W'(1);
      bg_on  = 1'b0;
      bg     = '1;
      errors = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRAY_MODE:   gray  = data[0];
        CFG_COLOR_COUNT: count = data[COUNT_W-1:0];
        CFG_BG_ENABLE:   bg_on = data[0];
        CFG_BG_RED:      bg.r  = data[7:0];
        CFG_BG_GREEN:    bg.g  = data[7:0];
        CFG_BG_BLUE:     bg.b  = data[7:0];
        default: ;
      endcase
    endfunction

    static function int cell_mid(int s, int bits);
      int sh;
      sh = 8 - bits;
      return ((s >> sh) << sh) + ((1 << sh) >> 1);
    endfunction

    function int nearest(int r, int g, int b);
      int cr, cg, cb, n, best, best_d, dr, dg, db, d, i;
      cr = cell_mid(r, RED_CELL_BITS);
      cg = cell_mid(g, GREEN_CELL_BITS);
      cb = cell_mid(b, BLUE_CELL_BITS);
      n = count;
      if (n == 0) n = 1;
      if (n > PAL_ENTRIES) n = PAL_ENTRIES;
      best   = 0;
      best_d = 32'h7FFF_FFFF;
      for (i = 0; i < n; i++) begin
        dr = (cr - int'(palette[i].r)) * 2;
        dg = (cg - int'(palette[i].g)) * 3;
        db = cb - int'(palette[i].b);
        d  = dr * dr + dg * dg + db * db;
        if (d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      return best;
    endfunction

    function void note_input(logic mode, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
      int            k, bk;
      mapped_pixel_t m;
      if (mode == MODE_WRITE) begin
        if (idx < PAL_ENTRIES) palette[idx] = {r, g, b};
        return;
      end
      m.sub = 1'b0;
      if (gray) begin
        k   = nearest(r, r, r);
        m.r = palette[k].r;
        m.g = '0;
        m.b = '0;
        if (bg_on) begin
          bk = nearest(bg.r, bg.r, bg.r);
          if (m.r == palette[bk].r) begin
            m.r   = bg.r;
            m.sub = 1'b1;
          end
        end
      end else begin
        k = nearest(r, g, b);
        {m.r, m.g, m.b} = palette[k];
        if (bg_on) begin
          bk = nearest(bg.r, bg.g, bg.b);
          if ({m.r, m.g, m.b} == palette[bk]) begin
            {m.r, m.g, m.b} = bg;
            m.sub = 1'b1;
          end
        end
      end
      m.idx = k[7:0];
      expected_q.push_back(m);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(mapped_pixel_t got);
      mapped_pixel_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: mapped pixel with none expected (red %0d green %0d blue %0d index %0d)",
                 $time, got.r, got.g, got.b, got.idx);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_red", want.r, got.r);
      compare_field("out_green", want.g, got.g);
      compare_field("out_blue", want.b, got.b);
      compare_field("chosen_index", want.idx, got.idx);
      compare_field("bg_substituted", 8'(want.sub), 8'(got.sub));
    endfunction
  endclass

endpackage

// ===== tb/sv/nearest_palette_color_mapper_tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for nearest_palette_color_mapper: directed and random palette
// loads and pixels under random idling. Uses npcm_pkg, npcm_ifs and npcm_tb_pkg.
module nearest_palette_color_mapper_tb;
  import npcm_pkg::*;
  import npcm_tb_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 600;
  localparam int ROUNDS       = 12;
  localparam int ROUND_COUNT [ROUNDS] = '{1, 256, 3, 17, 511, 40, 2, 8, 300, 0, 64, 12};

  logic clk;
  logic rst;

  npcm_pix_if pix ();
  npcm_res_if res ();
  npcm_cfg_if cfg ();

  nearest_palette_color_mapper DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  palette_map_scoreboard sb;
  int     send_idle_pct = 11;
  int     recv_idle_pct = 56;
  bit     loaded [PAL_ENTRIES];
  color_t shadow [PAL_ENTRIES];
  color_t bg_now;
  int     count_now = 1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL nearest_palette_color_mapper");
    $finish;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (pix.valid && pix.ready)
        sb.note_input(pix.mode, pix.entry_index, pix.red, pix.green, pix.blue);
      if (res.valid && res.ready)
        sb.check_result({res.out_red, res.out_green, res.out_blue, res.chosen_index,
                         res.bg_substituted});
    end
  end

  task automatic send_beat(logic mode, logic [7:0] idx, color_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid       = 1'b1;
    pix.mode        = mode;
    pix.entry_index = idx;
    pix.red         = c.r;
    pix.green       = c.g;
    pix.blue        = c.b;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  task automatic load_entry(logic [7:0] idx, color_t c);
    shadow[idx] = c;
    loaded[idx] = 1'b1;
    send_beat(MODE_WRITE, idx, c);
  endtask

  task automatic map_pixel(color_t c);
    send_beat(MODE_MAP, 8'($urandom), c);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    pix.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(bit gray, int count, bit bg_on, color_t bg);
    drain();
    set_reg(CFG_GRAY_MODE, int'(gray));
    set_reg(CFG_COLOR_COUNT, count);
    set_reg(CFG_BG_ENABLE, int'(bg_on));
    set_reg(CFG_BG_RED, int'(bg.r));
    set_reg(CFG_BG_GREEN, int'(bg.g));
    set_reg(CFG_BG_BLUE, int'(bg.b));
    bg_now    = bg;
    count_now = (count == 0) ? 1 : (count > PAL_ENTRIES) ? PAL_ENTRIES : count;
  endtask

  function automatic color_t corner_color();
    color_t c;
    c.r = $urandom_range(1) ? 8'hFF : 8'h00;
    c.g = $urandom_range(1) ? 8'hFF : 8'h00;
    c.b = $urandom_range(1) ? 8'hFF : 8'h00;
    return c;
  endfunction

  function automatic color_t palette_color();
    int     sel, src;
    color_t c;
    sel = $urandom_range(99);
    src = $urandom_range(PAL_ENTRIES - 1);
    c   = 24'($urandom);
    if (sel < 30 && loaded[src]) c = shadow[src];
    else if (sel < 45) c = corner_color();
    return c;
  endfunction

  function automatic color_t pixel_color();
    int     sel;
    color_t c;
    sel = $urandom_range(99);
    c   = 24'($urandom);
    if (sel < 20) begin
      c      = bg_now;
      c.r[0] = 1'($urandom_range(1));
      c.g[0] = 1'($urandom_range(1));
      c.b[0] = 1'($urandom_range(1));
    end else if (sel < 40) begin
      c = shadow[$urandom_range(count_now - 1)];
    end else if (sel < 48) begin
      c = corner_color();
    end
    return c;
  endfunction

  task automatic random_round(int rnd);
    bit     gray, bg_on;
    color_t bg;
    int     n_items, i;
    if (rnd < 4) begin
      send_idle_pct = 11;
      recv_idle_pct = 56;
    end else if (rnd < 8) begin
      send_idle_pct = 56;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    gray  = (rnd == 0) ? 1'b0 : (rnd == 1) ? 1'b1 : 1'($urandom);
    bg_on = (rnd == 0) ? 1'b1 : (rnd == 2) ? 1'b0 : ($urandom_range(9) < 7);
    bg    = (rnd == 0) ? '0 : (rnd == 1) ? '1 : 24'($urandom);
    configure(gray, ROUND_COUNT[rnd], bg_on, bg);
    for (i = 0; i < count_now; i++)
      if (!loaded[i]) load_entry(8'(i), palette_color());
    if ($urandom_range(1)) begin
      drain();
      bg_now = shadow[$urandom_range(count_now - 1)];
      set_reg(CFG_BG_RED, int'(bg_now.r));
      set_reg(CFG_BG_GREEN, int'(bg_now.g));
      set_reg(CFG_BG_BLUE, int'(bg_now.b));
    end
    n_items = (count_now > 64) ? 40 : 110;
    repeat (n_items) begin
      if ($urandom_range(99) < 15) load_entry(8'($urandom), palette_color());
      else map_pixel(pixel_color());
    end
  endtask

  initial begin
    int rnd;
    sb              = new();
    rst             = 1'b1;
    pix.valid       = 1'b0;
    pix.mode        = MODE_WRITE;
    pix.entry_index = '0;
    pix.red         = '0;
    pix.green       = '0;
    pix.blue        = '0;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_GRAY_MODE;
    cfg.data        = '0;
    bg_now          = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one entry searched after reset
    load_entry(8'd0, '0);
    map_pixel('0);
    map_pixel('1);
    // zero count still searches one entry
    configure(1'b0, 0, 1'b0, '1);
    map_pixel({8'd128, 8'd64, 8'd32});
    // duplicate red entries: lowest index wins, background hits the red one
    load_entry(8'd255, '1);
    load_entry(8'd1, {8'd255, 8'd0, 8'd0});
    load_entry(8'd2, {8'd0, 8'd255, 8'd0});
    load_entry(8'd3, {8'd0, 8'd0, 8'd255});
    load_entry(8'd4, {8'd255, 8'd0, 8'd0});
    configure(1'b0, 5, 1'b1, {8'd250, 8'd5, 8'd5});
    map_pixel({8'd240, 8'd10, 8'd10});
    map_pixel('0);
    map_pixel({8'd1, 8'd2, 8'd3});
    // gray: only red decides substitution
    configure(1'b1, 5, 1'b1, '0);
    map_pixel({8'd0, 8'd255, 8'd255});
    map_pixel({8'd200, 8'd0, 8'd0});
    map_pixel('1);

    for (rnd = 0; rnd < ROUNDS; rnd++) random_round(rnd);

    pix.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS nearest_palette_color_mapper");
    end else begin
      $display("FAIL nearest_palette_color_mapper");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/npcm_pkg.sv
src/npcm_ifs.sv
src/npcm_ram.sv
src/npcm_dist.sv
src/nearest_palette_color_mapper.sv
tb/sv/npcm_tb_pkg.sv
tb/sv/nearest_palette_color_mapper_tb.sv
